>>> sv/elic_pkg.sv
// Shared types and constants of the epipolar line image clip unit.
// No dependencies; every other file of the block imports this package.
package elic_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_EDGES  = 4;
    localparam int POS_W      = 18;   // doubled edge position, signed
    localparam int NUM_W      = 82;   // kfix*pos2 + 2c, signed
    localparam int DEN_W      = 64;
    localparam int MAG_LOW    = NUM_W - DEN_W;
    localparam int FRAC_SHIFT = 11;
    localparam int DIV_BITS   = MAG_LOW + FRAC_SHIFT;
    localparam int LANE_LAT   = DIV_BITS + 2;

    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_TOP    = 1;
    localparam int EDGE_BOTTOM = 2;
    localparam int EDGE_RIGHT  = 3;

    localparam logic signed [31:0] Q12_ONE = 32'sd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_A,
        CFG_PAIR_B,
        CFG_PAIR_C,
        CFG_PAIR_D,
        CFG_LAST,
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_CENTRED
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0][63:0] pair;
        logic [31:0]      last;
        logic [15:0]      width;
        logic [15:0]      height;
        logic             centred;
    } t_cfg;

    typedef struct packed {
        logic signed [63:0]                line_a;
        logic signed [63:0]                line_b;
        logic signed [63:0]                line_c;
        logic [NUM_EDGES-1:0][NUM_W-1:0]   num;
        logic [NUM_EDGES-1:0]              skip;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> sv/elic_front.sv
// Front end: forms the epipolar line and the per-edge numerators.
// Depends on elic_pkg; feeds the queue in elic_fifo.
module elic_front import elic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_w,
    input  logic               i_use_transpose,
    input  logic               i_q_full,
    output logic               o_push,
    output t_item              o_item
);

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [31:0] coef [9];
    logic signed [31:0] pt   [3];
    logic signed [63:0] r_prod [3][3];
    logic signed [65:0] n_sum  [3];
    logic signed [63:0] n_line [3];
    logic signed [63:0] r_line2 [3];

    logic signed [POS_W-1:0]  pos2 [NUM_EDGES];
    logic signed [POS_W+32:0] n_lo [NUM_EDGES];
    logic signed [POS_W+31:0] n_hi [NUM_EDGES];
    logic signed [POS_W+32:0] r_lo [NUM_EDGES];
    logic signed [POS_W+31:0] r_hi [NUM_EDGES];
    logic [NUM_EDGES-1:0]     n_skip3, r_skip3;
    logic signed [63:0]       r_line3 [3];
    logic signed [NUM_W-1:0]  n_num [NUM_EDGES];
    t_item                    r_item;

    logic signed [POS_W-1:0] w_pos, h_pos;

    assign adv     = !(r_v4 && i_q_full);
    assign o_stall = !adv;
    assign o_push  = r_v4 && !i_q_full;
    assign o_item  = r_item;

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_w;

    for (genvar g = 0; g < 4; g++) begin : g_coef
        assign coef[2*g]   = i_cfg.pair[g][31:0];
        assign coef[2*g+1] = i_cfg.pair[g][63:32];
    end
    assign coef[8] = i_cfg.last;

    // Stage 1: the nine products, F or its transpose picked per entry.
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar k = 0; k < 3; k++) begin : g_col
            logic signed [31:0] c_sel;
            logic signed [63:0] n_prod;
            assign c_sel  = i_use_transpose ? coef[k*3+r] : coef[r*3+k];
            assign n_prod = c_sel * pt[k];
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_prod[r][k] <= n_prod;
                end
            end
        end

        // Stage 2: exact sum of three, saturated to 64 bits.
        assign n_sum[r] = $signed({{2{r_prod[r][0][63]}}, r_prod[r][0]})
                        + $signed({{2{r_prod[r][1][63]}}, r_prod[r][1]})
                        + $signed({{2{r_prod[r][2][63]}}, r_prod[r][2]});
        always_comb begin
            if (n_sum[r][65:63] == 3'b000 || n_sum[r][65:63] == 3'b111) begin
                n_line[r] = n_sum[r][63:0];
            end else if (n_sum[r][65]) begin
                n_line[r] = 64'sh8000_0000_0000_0000;
            end else begin
                n_line[r] = 64'sh7FFF_FFFF_FFFF_FFFF;
            end
        end
    end

    // Stage 3: edge positions and partial products of kfix * pos2.
    assign w_pos = $signed({2'b00, i_cfg.width});
    assign h_pos = $signed({2'b00, i_cfg.height});
    assign pos2[EDGE_LEFT]   = i_cfg.centred ? -w_pos : '0;
    assign pos2[EDGE_TOP]    = i_cfg.centred ? h_pos : '0;
    assign pos2[EDGE_BOTTOM] = i_cfg.centred ? -h_pos : $signed({1'b0, i_cfg.height, 1'b0});
    assign pos2[EDGE_RIGHT]  = i_cfg.centred ? w_pos : $signed({1'b0, i_cfg.width, 1'b0});

    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
        logic signed [63:0] kfix;
        logic signed [NUM_W-1:0] hi_x, lo_x, c_x;
        if (e == EDGE_LEFT || e == EDGE_RIGHT) begin : g_vert
            assign kfix = r_line2[0];
            assign n_skip3[e] = (i_cfg.height == 16'd0) || (r_line2[1] == 64'sd0);
        end else begin : g_horz
            assign kfix = r_line2[1];
            assign n_skip3[e] = (i_cfg.width == 16'd0) || (r_line2[0] == 64'sd0);
        end
        assign n_lo[e] = $signed({1'b0, kfix[31:0]}) * pos2[e];
        assign n_hi[e] = $signed(kfix[63:32]) * pos2[e];

        // Stage 4: numerator kfix*pos2 + 2c.
        assign hi_x = NUM_W'(r_hi[e]);
        assign lo_x = NUM_W'(r_lo[e]);
        assign c_x  = NUM_W'(r_line3[2]);
        assign n_num[e] = (hi_x <<< 32) + lo_x + (c_x <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_line2 <= n_line;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_skip3 <= n_skip3;
            r_line3 <= r_line2;
            r_item.line_a <= r_line3[0];
            r_item.line_b <= r_line3[1];
            r_item.line_c <= r_line3[2];
            r_item.skip   <= r_skip3;
            for (int e = 0; e < NUM_EDGES; e++) begin
                r_item.num[e] <= n_num[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

endmodule

>>> sv/elic_fifo.sv
// Short queue between the front end and the back end.
// Depends on elic_pkg for the item and status types.
module elic_fifo import elic_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_data,
    input  logic      i_pop,
    output t_item     o_head,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue read while empty");

endmodule

>>> sv/elic_div_lane.sv
// One edge's quotient pipeline: sign handling, range check and a
// restoring divider that retires one quotient bit per stage. Uses elic_pkg.
module elic_div_lane import elic_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    input  logic                    i_skip,
    output logic [DIV_BITS-1:0]     o_q,
    output logic                    o_inexact,
    output logic                    o_big,
    output logic                    o_neg,
    output logic                    o_skip
);

    logic             sn, sd;
    logic [NUM_W-1:0] n_mag, r_mag;
    logic [DEN_W-1:0] n_md, r_md_a;
    logic             r_neg_a, r_skip_a;

    logic [DEN_W-1:0]    r_rem  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_low  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_q    [DIV_BITS+1];
    logic [DEN_W-1:0]    r_md   [DIV_BITS+1];
    logic                r_big  [DIV_BITS+1];
    logic                r_neg  [DIV_BITS+1];
    logic                r_skip [DIV_BITS+1];

    // The quotient is of -num: negative when num > 0 and den >= 0, or when num <= 0 and den < 0.
    assign sn    = !i_num[NUM_W-1] && (i_num != '0);
    assign sd    = i_den[DEN_W-1];
    assign n_mag = i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
    assign n_md  = sd ? $unsigned(-i_den) : $unsigned(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= n_mag;
            r_md_a   <= n_md;
            r_neg_a  <= (sn != sd);
            r_skip_a <= i_skip;
            // A quotient of 2^DIV_BITS or more lies outside every bound.
            r_big[0]  <= (r_mag >= {r_md_a, {MAG_LOW{1'b0}}});
            r_rem[0]  <= r_mag[NUM_W-1 -: DEN_W];
            r_low[0]  <= {r_mag[MAG_LOW-1:0], {FRAC_SHIFT{1'b0}}};
            r_q[0]    <= '0;
            r_md[0]   <= r_md_a;
            r_neg[0]  <= r_neg_a;
            r_skip[0] <= r_skip_a;
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
        logic [DEN_W:0] tmp, diff;
        logic           ge;
        assign tmp  = {r_rem[j], r_low[j][DIV_BITS-1]};
        assign diff = tmp - {1'b0, r_md[j]};
        assign ge   = (tmp >= {1'b0, r_md[j]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= ge ? diff[DEN_W-1:0] : tmp[DEN_W-1:0];
                r_low[j+1]  <= r_low[j] << 1;
                r_q[j+1]    <= {r_q[j][DIV_BITS-2:0], ge};
                r_md[j+1]   <= r_md[j];
                r_big[j+1]  <= r_big[j];
                r_neg[j+1]  <= r_neg[j];
                r_skip[j+1] <= r_skip[j];
            end
        end
    end

    assign o_q       = r_q[DIV_BITS];
    assign o_inexact = (r_rem[DIV_BITS] != '0);
    assign o_big     = r_big[DIV_BITS];
    assign o_neg     = r_neg[DIV_BITS];
    assign o_skip    = r_skip[DIV_BITS];

endmodule

>>> sv/elic_back.sv
// Back end: four quotient lanes, bounds test, hit selection and the
// output register. Depends on elic_pkg and elic_div_lane.
module elic_back import elic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    output logic               o_pop,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_valid_res,
    output logic [2:0]         o_hit_count,
    output logic signed [31:0] o_end1_x,
    output logic signed [31:0] o_end1_y,
    output logic signed [31:0] o_end2_x,
    output logic signed [31:0] o_end2_y,
    output logic signed [63:0] o_line_a,
    output logic signed [63:0] o_line_b,
    output logic signed [63:0] o_line_c
);

    logic adv;
    logic r_vld [LANE_LAT];
    logic signed [63:0] r_la [LANE_LAT];
    logic signed [63:0] r_lb [LANE_LAT];
    logic signed [63:0] r_lc [LANE_LAT];

    logic [DIV_BITS-1:0] l_q [NUM_EDGES];
    logic [NUM_EDGES-1:0] l_inexact, l_big, l_neg, l_skip;

    logic [NUM_EDGES-1:0] n_keep, r_keep;
    logic signed [31:0]   n_ex [NUM_EDGES];
    logic signed [31:0]   n_ey [NUM_EDGES];
    logic signed [31:0]   r_ex [NUM_EDGES];
    logic signed [31:0]   r_ey [NUM_EDGES];
    logic                 r_vk;
    logic signed [63:0]   r_la_k, r_lb_k, r_lc_k;

    logic signed [31:0] w4096, w2048, h4096, h2048;

    logic [2:0]         n_cnt;
    logic               n_vres, have1, have2;
    logic signed [31:0] e1x, e1y, e2x, e2y;

    assign adv   = !o_valid || !i_stall;
    assign o_pop = adv && !i_q_empty;

    for (genvar g = 0; g < NUM_EDGES; g++) begin : g_lane
        logic signed [DEN_W-1:0] den;
        if (g == EDGE_LEFT || g == EDGE_RIGHT) begin : g_vert
            assign den = i_item.line_b;
        end else begin : g_horz
            assign den = i_item.line_a;
        end
        elic_div_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (adv),
            .i_num     ($signed(i_item.num[g])),
            .i_den     (den),
            .i_skip    (i_item.skip[g]),
            .o_q       (l_q[g]),
            .o_inexact (l_inexact[g]),
            .o_big     (l_big[g]),
            .o_neg     (l_neg[g]),
            .o_skip    (l_skip[g])
        );
    end

    // The lines ride alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_la[0] <= i_item.line_a;
            r_lb[0] <= i_item.line_b;
            r_lc[0] <= i_item.line_c;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_la[s] <= r_la[s-1];
                r_lb[s] <= r_lb[s-1];
                r_lc[s] <= r_lc[s-1];
            end
        end
    end

    assign w4096 = $signed({4'b0, i_cfg.width, 12'b0});
    assign w2048 = $signed({5'b0, i_cfg.width, 11'b0});
    assign h4096 = $signed({4'b0, i_cfg.height, 12'b0});
    assign h2048 = $signed({5'b0, i_cfg.height, 11'b0});

    // Bounds test on the exact quotient. The fixed coordinate of each edge
    // always lies on the rectangle, so only the free one is tested.
    for (genvar g = 0; g < NUM_EDGES; g++) begin : g_test
        logic signed [31:0] q_ext, v, hib, lob, fixc;
        logic               outside;
        assign q_ext = $signed(32'(l_q[g]));
        assign v = l_neg[g] ? -(q_ext + $signed(32'(l_inexact[g]))) : q_ext;
        if (g == EDGE_LEFT || g == EDGE_RIGHT) begin : g_vert
            assign hib = i_cfg.centred ? h2048 + Q12_ONE : h4096;
        end else begin : g_horz
            assign hib = i_cfg.centred ? w2048 + Q12_ONE : w4096;
        end
        assign lob = i_cfg.centred ? -hib : '0;
        if (g == EDGE_LEFT) begin : g_l
            assign fixc = i_cfg.centred ? -w2048 : '0;
        end else if (g == EDGE_TOP) begin : g_t
            assign fixc = i_cfg.centred ? h2048 : '0;
        end else if (g == EDGE_BOTTOM) begin : g_b
            assign fixc = i_cfg.centred ? -h2048 : h4096;
        end else begin : g_r
            assign fixc = i_cfg.centred ? w2048 : w4096;
        end
        assign outside = l_big[g] || (v < lob) || (v > hib)
                       || ((v == hib) && l_inexact[g]);
        assign n_keep[g] = !l_skip[g] && !outside;
        if (g == EDGE_LEFT || g == EDGE_RIGHT) begin : g_xy_v
            assign n_ex[g] = fixc;
            assign n_ey[g] = v;
        end else begin : g_xy_h
            assign n_ex[g] = v;
            assign n_ey[g] = fixc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_keep <= n_keep;
            r_ex   <= n_ex;
            r_ey   <= n_ey;
            r_la_k <= r_la[LANE_LAT-1];
            r_lb_k <= r_lb[LANE_LAT-1];
            r_lc_k <= r_lc[LANE_LAT-1];
        end
    end

    // First two kept hits in edge order.
    always_comb begin
        n_cnt = '0;
        have1 = 1'b0;
        have2 = 1'b0;
        e1x   = '0;
        e1y   = '0;
        e2x   = '0;
        e2y   = '0;
        for (int i = 0; i < NUM_EDGES; i++) begin
            n_cnt = n_cnt + {2'b00, r_keep[i]};
            if (r_keep[i]) begin
                if (!have1) begin
                    e1x   = r_ex[i];
                    e1y   = r_ey[i];
                    have1 = 1'b1;
                end else if (!have2) begin
                    e2x   = r_ex[i];
                    e2y   = r_ey[i];
                    have2 = 1'b1;
                end
            end
        end
        n_vres = (n_cnt == 3'd2) || (n_cnt == 3'd4);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_valid_res <= n_vres;
            o_hit_count <= n_cnt;
            o_end1_x    <= n_vres ? e1x : '0;
            o_end1_y    <= n_vres ? e1y : '0;
            o_end2_x    <= n_vres ? e2x : '0;
            o_end2_y    <= n_vres ? e2y : '0;
            o_line_a    <= r_la_k;
            o_line_b    <= r_lb_k;
            o_line_c    <= r_lc_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_vk    <= 1'b0;
            o_valid <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= o_pop;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_vk    <= r_vld[LANE_LAT-1];
            o_valid <= r_vk;
        end
    end

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> (o_hit_count == 3'd2 || o_hit_count == 3'd4))
        else $error("valid result with a hit count other than two or four");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |->
            (o_end1_x == '0 && o_end1_y == '0 && o_end2_x == '0 && o_end2_y == '0))
        else $error("invalid result carries nonzero endpoints");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_hit_count) && $stable(o_end1_x) && $stable(o_end2_y)
             && $stable(o_line_a) && $stable(o_line_c)))
        else $error("stalled result changed");

endmodule

>>> sv/epipolar_line_image_clip_unit.sv
// Top level of the epipolar line image clip unit: configuration registers,
// front end, queue and back end. Depends on elic_pkg, elic_front,
// elic_fifo and elic_back.
//
// The unit takes one homogeneous point per transaction, forms the epipolar
// line F*x (or F transposed times x), crosses it with the left, top, bottom
// and right image edges and reports the first two kept hits when exactly two
// or four survive the bounds test of the selected mode. It sustains one
// transaction per clock cycle while nothing stalls; a result passes the four
// front stages, then the queue write, the quotient lanes and the two closing
// stages before it reaches the outputs. Each edge has its own quotient lane,
// a restoring divider that retires one quotient bit per stage with a 65-bit
// compare and subtract. The front end and the back end are parted by a short
// queue, so a stall at the result side reaches the point side only once the
// queue has filled. Configuration is written through its own channel, whose
// ready is always high; registers should be written only while no
// transaction is in flight. No memory needs clearing after reset.
module epipolar_line_image_clip_unit import elic_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_point_x,
    input  logic signed [31:0]    i_point_y,
    input  logic signed [31:0]    i_point_w,
    input  logic                  i_use_transpose,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_valid_res,
    output logic [2:0]            o_hit_count,
    output logic signed [31:0]    o_end1_x,
    output logic signed [31:0]    o_end1_y,
    output logic signed [31:0]    o_end2_x,
    output logic signed [31:0]    o_end2_y,
    output logic signed [63:0]    o_line_a,
    output logic signed [63:0]    o_line_b,
    output logic signed [63:0]    o_line_c
);

    t_cfg      r_cfg;
    t_item     push_item, head_item;
    logic      push, pop;
    t_q_status q_status;

    // Registers are always ready, so every valid beat is a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pair    <= '0;
            r_cfg.last    <= '0;
            r_cfg.width   <= 16'd640;
            r_cfg.height  <= 16'd480;
            r_cfg.centred <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PAIR_A:  r_cfg.pair[0] <= i_cfg_data;
                CFG_PAIR_B:  r_cfg.pair[1] <= i_cfg_data;
                CFG_PAIR_C:  r_cfg.pair[2] <= i_cfg_data;
                CFG_PAIR_D:  r_cfg.pair[3] <= i_cfg_data;
                CFG_LAST:    r_cfg.last    <= i_cfg_data[31:0];
                CFG_WIDTH:   r_cfg.width   <= i_cfg_data[15:0];
                CFG_HEIGHT:  r_cfg.height  <= i_cfg_data[15:0];
                CFG_CENTRED: r_cfg.centred <= i_cfg_data[0];
            endcase
        end
    end

    // Front end: line products, saturation and a numerator for each of the left, top, bottom and right edges.
    elic_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_w       (i_point_w),
        .i_use_transpose (i_use_transpose),
        .i_q_full        (q_status.full),
        .o_push          (push),
        .o_item          (push_item)
    );

    // The queue lets the front end keep accepting while the result side
    // holds the back end.
    elic_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    // Back end: quotients, bounds test, hit selection, output register.
    elic_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_status.empty),
        .o_pop       (pop),
        .i_item      (head_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_valid_res (o_valid_res),
        .o_hit_count (o_hit_count),
        .o_end1_x    (o_end1_x),
        .o_end1_y    (o_end1_y),
        .o_end2_x    (o_end2_x),
        .o_end2_y    (o_end2_y),
        .o_line_a    (o_line_a),
        .o_line_b    (o_line_b),
        .o_line_c    (o_line_c)
    );

endmodule
